@@ sv/csi_u_key_event_decoder_macros.svh @@
// Assertion macros for the checker file of the key event decoder.
`ifndef CSI_U_KEY_EVENT_DECODER_MACROS_SVH
`define CSI_U_KEY_EVENT_DECODER_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define CEKD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define CEKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define CEKD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cekd_pkg.sv @@
package cekd_pkg;

    // Bytes with a fixed meaning in the terminal stream.
    localparam logic [7:0] C_ESC      = 8'h1b;
    localparam logic [7:0] C_LBRACKET = 8'h5b;
    localparam logic [7:0] C_FINAL_LO = 8'h40;
    localparam logic [7:0] C_FINAL_HI = 8'h7e;
    localparam logic [7:0] C_FINAL_U  = 8'h75;
    localparam logic [7:0] C_SEMI     = 8'h3b;
    localparam logic [7:0] C_COLON    = 8'h3a;
    localparam logic [7:0] C_DIGIT_LO = 8'h30;
    localparam logic [7:0] C_DIGIT_HI = 8'h39;

    // Event type of a plain press.
    localparam logic [7:0] C_PRESS = 8'd1;

    // Width in bits of the event type that a sequence may carry.
    localparam int C_EVENT_BITS = 8;

    // Output word queue.
    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_AW    = 2;
    localparam int C_Q_CW    = 3;

    // Progress of a leading-digit scan.
    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_RUN,
        SCAN_DONE,
        SCAN_BAD
    } t_scan_st;

endpackage

@@ sv/cekd_if.sv @@
// Byte channel into the decoder.
interface cekd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// Key event channel out of the decoder.
interface cekd_event_if #(
    parameter int KEY_BITS = 21
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] key_code;
    logic [7:0]          event_kind;
    logic                last_of_run;

    modport source (output valid, output key_code, output event_kind,
                    output last_of_run, input ready);
    modport sink (input valid, input key_code, input event_kind,
                  input last_of_run, output ready);
endinterface

@@ sv/cekd_core.sv @@
module cekd_core
    import cekd_pkg::*;
#(
    parameter int KEY_BITS = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    output logic [1:0]          o_n_ev,
    output logic [KEY_BITS-1:0] o_ev0_key,
    output logic [7:0]          o_ev0_kind,
    output logic                o_ev0_last,
    output logic [KEY_BITS-1:0] o_ev1_key
);

    localparam int MulW = KEY_BITS + 4;
    localparam int EvMulW = C_EVENT_BITS + 4;

    typedef enum logic [1:0] {
        PH_GROUND,
        PH_ESC,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        FS_KEY,
        FS_SEMI,
        FS_EVENT
    } t_field;

    t_phase                   r_phase, n_phase;
    t_field                   r_field, n_field;
    t_scan_st                 r_key_st, n_key_st;
    t_scan_st                 r_ev_st, n_ev_st;
    logic [KEY_BITS-1:0]      r_key_acc, n_key_acc;
    logic [C_EVENT_BITS-1:0]  r_ev_acc, n_ev_acc;

    logic                     is_digit;
    logic [3:0]               dval;
    logic [MulW-1:0]          key_mul;
    logic [EvMulW-1:0]        ev_mul;
    logic                     key_ok;

    // Decimal step of both accumulators: acc * 10 + digit.
    assign is_digit = (i_byte >= C_DIGIT_LO) && (i_byte <= C_DIGIT_HI);
    assign dval     = i_byte[3:0];
    assign key_mul  = (MulW'(r_key_acc) << 3) + (MulW'(r_key_acc) << 1) + MulW'(dval);
    assign ev_mul   = (EvMulW'(r_ev_acc) << 3) + (EvMulW'(r_ev_acc) << 1) + EvMulW'(dval);

    // The second word of a byte is always a plain press of that byte.
    assign o_ev1_key = KEY_BITS'(i_byte);

    // Next state and the words that this byte gives.
    always_comb begin
        n_phase    = r_phase;
        n_field    = r_field;
        n_key_st   = r_key_st;
        n_ev_st    = r_ev_st;
        n_key_acc  = r_key_acc;
        n_ev_acc   = r_ev_acc;
        o_n_ev     = 2'd0;
        o_ev0_key  = KEY_BITS'(i_byte);
        o_ev0_kind = C_PRESS;
        o_ev0_last = 1'b1;
        key_ok     = 1'b0;

        case (r_phase)
            PH_ESC: begin
                if (i_byte == C_LBRACKET) begin
                    n_phase   = PH_BODY;
                    n_field   = FS_KEY;
                    n_key_st  = SCAN_NONE;
                    n_ev_st   = SCAN_NONE;
                    n_key_acc = '0;
                    n_ev_acc  = '0;
                end else if (i_byte == C_ESC) begin
                    o_n_ev    = 2'd1;
                    o_ev0_key = KEY_BITS'(C_ESC);
                end else begin
                    n_phase    = PH_GROUND;
                    o_n_ev     = 2'd2;
                    o_ev0_key  = KEY_BITS'(C_ESC);
                    o_ev0_last = 1'b0;
                end
            end

            PH_BODY: begin
                if ((i_byte >= C_FINAL_LO) && (i_byte <= C_FINAL_HI)) begin
                    // Final byte: only 'u' with a valid key, and a valid event type if one is given, gives a word.
                    n_phase    = PH_GROUND;
                    key_ok     = (r_key_st == SCAN_RUN) || (r_key_st == SCAN_DONE);
                    o_ev0_key  = r_key_acc;
                    if (r_field == FS_EVENT) begin
                        if ((r_ev_st == SCAN_RUN) || (r_ev_st == SCAN_DONE)) begin
                            o_ev0_kind = r_ev_acc;
                        end else begin
                            key_ok = 1'b0;
                        end
                    end
                    if ((i_byte == C_FINAL_U) && key_ok) begin
                        o_n_ev = 2'd1;
                    end
                end else begin
                    // Leading key digits.
                    case (r_key_st)
                        SCAN_NONE: begin
                            if (is_digit) begin
                                n_key_acc = KEY_BITS'(dval);
                                n_key_st  = SCAN_RUN;
                            end else begin
                                n_key_st = SCAN_BAD;
                            end
                        end
                        SCAN_RUN: begin
                            if (!is_digit) begin
                                n_key_st = SCAN_DONE;
                            end else if (key_mul[MulW-1:KEY_BITS] != '0) begin
                                n_key_st  = SCAN_BAD;
                                n_key_acc = '0;
                            end else begin
                                n_key_acc = key_mul[KEY_BITS-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase

                    // Field position and the event digits.
                    case (r_field)
                        FS_KEY: begin
                            if (i_byte == C_SEMI) begin
                                n_field = FS_SEMI;
                            end
                        end
                        FS_SEMI: begin
                            if (i_byte == C_COLON) begin
                                n_field  = FS_EVENT;
                                n_ev_acc = '0;
                                n_ev_st  = SCAN_NONE;
                            end
                        end
                        default: begin
                            case (r_ev_st)
                                SCAN_NONE: begin
                                    if (is_digit) begin
                                        n_ev_acc = C_EVENT_BITS'(dval);
                                        n_ev_st  = SCAN_RUN;
                                    end else begin
                                        n_ev_st = SCAN_BAD;
                                    end
                                end
                                SCAN_RUN: begin
                                    if (!is_digit) begin
                                        n_ev_st = SCAN_DONE;
                                    end else if (ev_mul[EvMulW-1:C_EVENT_BITS] != '0) begin
                                        n_ev_st  = SCAN_BAD;
                                        n_ev_acc = '0;
                                    end else begin
                                        n_ev_acc = ev_mul[C_EVENT_BITS-1:0];
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
            end

            default: begin
                // Ground: ESC waits, anything else is a press.
                n_phase = PH_GROUND;
                if (i_byte == C_ESC) begin
                    n_phase = PH_ESC;
                end else begin
                    o_n_ev = 2'd1;
                end
            end
        endcase
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_GROUND;
            r_field   <= FS_KEY;
            r_key_st  <= SCAN_NONE;
            r_ev_st   <= SCAN_NONE;
            r_key_acc <= '0;
            r_ev_acc  <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_field   <= n_field;
            r_key_st  <= n_key_st;
            r_ev_st   <= n_ev_st;
            r_key_acc <= n_key_acc;
            r_ev_acc  <= n_ev_acc;
        end
    end

endmodule

@@ sv/csi_u_key_event_decoder.sv @@
// Decodes a terminal input byte stream into key event words, one byte per
// clock while the output queue has room for two words. A plain byte gives a
// press of that byte; ESC followed by a byte other than '[' or ESC gives a
// press of key 27 and then a press of that byte, so one byte can give two
// words; a second ESC gives a press of key 27 and is held as a new ESC; ESC
// '[' ... 'u' gives the decoded key code and event type, and any other or
// malformed sequence gives nothing. A byte that is taken sits in the input
// register and is decoded once the output queue has room for two words;
// its words are then written to the output queue, from which the first of
// them is offered. A new byte can be taken every clock while that room
// lasts; a byte that gives two words hands them out one after the other,
// and a four-word output queue takes up the difference. The
// key_code width of the event channel must match KEY_BITS.
module csi_u_key_event_decoder
    import cekd_pkg::*;
#(
    parameter int KEY_BITS = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cekd_byte_if.sink         i_byte_ch,
    cekd_event_if.source      o_event_ch
);

    logic                r_in_vld;
    logic [7:0]          r_in_byte;

    logic [KEY_BITS-1:0] r_q_key  [C_Q_DEPTH];
    logic [7:0]          r_q_kind [C_Q_DEPTH];
    logic                r_q_last [C_Q_DEPTH];
    logic [C_Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [C_Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [C_Q_CW-1:0]   r_q_count, n_q_count;

    logic                proc_fire;
    logic                pop;
    logic [1:0]          n_ev;
    logic [KEY_BITS-1:0] ev0_key;
    logic [7:0]          ev0_kind;
    logic                ev0_last;
    logic [KEY_BITS-1:0] ev1_key;
    logic [C_Q_AW-1:0]   wr_ptr_p1;

    // A byte is decoded once the queue has room for two words.
    assign proc_fire       = r_in_vld && (r_q_count <= C_Q_CW'(C_Q_DEPTH - 2));
    assign i_byte_ch.ready = !r_in_vld || proc_fire;
    assign pop             = o_event_ch.valid && o_event_ch.ready;
    assign wr_ptr_p1       = r_wr_ptr + C_Q_AW'(1);

    cekd_core #(
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (proc_fire),
        .i_byte     (r_in_byte),
        .o_n_ev     (n_ev),
        .o_ev0_key  (ev0_key),
        .o_ev0_kind (ev0_kind),
        .o_ev0_last (ev0_last),
        .o_ev1_key  (ev1_key)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_vld <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.valid && i_byte_ch.ready) begin
            r_in_byte <= i_byte_ch.data_byte;
        end
    end

    // Queue pointers and fill level.
    always_comb begin
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_q_count = r_q_count;
        if (proc_fire) begin
            n_wr_ptr  = r_wr_ptr + C_Q_AW'(n_ev);
            n_q_count = n_q_count + C_Q_CW'(n_ev);
        end
        if (pop) begin
            n_rd_ptr  = r_rd_ptr + C_Q_AW'(1);
            n_q_count = n_q_count - C_Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_q_count <= n_q_count;
        end
    end

    // Queue storage: the first word at the write pointer, a second one after it.
    always_ff @(posedge i_clk) begin
        if (proc_fire && (n_ev != 2'd0)) begin
            r_q_key[r_wr_ptr]  <= ev0_key;
            r_q_kind[r_wr_ptr] <= ev0_kind;
            r_q_last[r_wr_ptr] <= ev0_last;
        end
        if (proc_fire && (n_ev == 2'd2)) begin
            r_q_key[wr_ptr_p1]  <= ev1_key;
            r_q_kind[wr_ptr_p1] <= C_PRESS;
            r_q_last[wr_ptr_p1] <= 1'b1;
        end
    end

    // Output word.
    assign o_event_ch.valid       = (r_q_count != '0);
    assign o_event_ch.key_code    = r_q_key[r_rd_ptr];
    assign o_event_ch.event_kind  = r_q_kind[r_rd_ptr];
    assign o_event_ch.last_of_run = r_q_last[r_rd_ptr];

endmodule

@@ sv/cekd_chk.sv @@
`include "csi_u_key_event_decoder_macros.svh"

module cekd_chk
    import cekd_pkg::*;
#(
    parameter int KEY_BITS = 21
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [KEY_BITS-1:0] i_key_code,
    input logic [7:0]          i_event_kind,
    input logic                i_last_of_run
);

    // No word is offered straight after reset.
    `CEKD_ASSERT_ALWAYS_NEXT(a_rst_idle, i_clk, !i_rst_n, !i_out_valid, "word offered after reset")

    // A stalled word stays put.
    `CEKD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_key_code) && $stable(i_event_kind) && $stable(i_last_of_run), "stalled word changed")

    // A word that is not the last of its byte is always the ESC press.
    `CEKD_ASSERT_NOW(a_first_esc, i_clk, i_rst_n, i_out_valid && !i_last_of_run, (i_key_code == KEY_BITS'(C_ESC)) && (i_event_kind == C_PRESS), "leading word is not an ESC press")

    // The second word of a pair is already queued behind the first.
    `CEKD_ASSERT_NEXT(a_pair_ready, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_of_run, i_out_valid, "second word of a pair missing")

endmodule

bind csi_u_key_event_decoder cekd_chk #(
    .KEY_BITS (KEY_BITS)
) u_cekd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_event_ch.valid),
    .i_out_ready   (o_event_ch.ready),
    .i_key_code    (o_event_ch.key_code),
    .i_event_kind  (o_event_ch.event_kind),
    .i_last_of_run (o_event_ch.last_of_run)
);

@@ bench/key_event_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the key event decoder, works out the key event
// words that each accepted byte must give, and compares them in order with
// the words that the decoder hands out.
module key_event_checker
    import cekd_pkg::*;
#(
    parameter int KEY_BITS = 21
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_byte_valid,
    input  logic                i_byte_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_event_valid,
    input  logic                i_event_ready,
    input  logic [KEY_BITS-1:0] i_key_code,
    input  logic [7:0]          i_event_kind,
    input  logic                i_last_of_run,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [31:0] KEY_LIMIT  = (32'd1 << KEY_BITS) - 32'd1;
    localparam logic [31:0] KIND_LIMIT = (32'd1 << C_EVENT_BITS) - 32'd1;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [7:0]          kind;
        logic                last;
    } t_key_event;

    typedef enum logic [1:0] {
        PH_GROUND,
        PH_ESC,
        PH_BODY
    } t_stream_phase;

    typedef enum logic [1:0] {
        FLD_KEY,
        FLD_MODS,
        FLD_KIND
    } t_csi_field;

    // Shadow copy of the decoder's state.
    t_stream_phase phase;
    logic [31:0]   key_acc;
    t_scan_st      key_st;
    t_csi_field    field;
    logic [31:0]   kind_acc;
    t_scan_st      kind_st;

    t_key_event due_events[$];
    int         fails = 0;

    function automatic t_key_event make_event(input logic [KEY_BITS-1:0] key,
                                              input logic [7:0] kind,
                                              input logic last);
        make_event.key  = key;
        make_event.kind = kind;
        make_event.last = last;
    endfunction

    // Appends one expected word at the tail of the queue.
    function automatic void queue_event(input t_key_event ev);
        due_events.insert(due_events.size(), ev);
    endfunction

    // Moves one leading-digit scan on by one byte; a value past the limit
    // spoils the scan for the rest of the sequence.
    task automatic scan_digit(input logic [7:0] b, input logic [31:0] limit,
                              inout logic [31:0] acc, inout t_scan_st st);
        logic        is_digit;
        logic [35:0] next_val;
        is_digit = (b >= C_DIGIT_LO) && (b <= C_DIGIT_HI);
        case (st)
            SCAN_NONE: begin
                if (is_digit) begin
                    acc = 32'(b - C_DIGIT_LO);
                    st  = SCAN_RUN;
                end else begin
                    st = SCAN_BAD;
                end
            end
            SCAN_RUN: begin
                if (is_digit) begin
                    next_val = {4'd0, acc} * 36'd10 + 36'(b - C_DIGIT_LO);
                    if (next_val > {4'd0, limit}) begin
                        st  = SCAN_BAD;
                        acc = '0;
                    end else begin
                        acc = next_val[31:0];
                    end
                end else begin
                    st = SCAN_DONE;
                end
            end
            default: ;
        endcase
    endtask

    // Works out the words caused by one byte and queues them.
    task automatic decode_byte(input logic [7:0] b);
        logic       ok;
        logic [7:0] kind;
        case (phase)
            PH_GROUND: begin
                if (b == C_ESC) begin
                    phase = PH_ESC;
                end else begin
                    queue_event(make_event(KEY_BITS'(b), C_PRESS, 1'b1));
                end
            end
            PH_ESC: begin
                if (b == C_LBRACKET) begin
                    phase    = PH_BODY;
                    key_acc  = '0;
                    key_st   = SCAN_NONE;
                    field    = FLD_KEY;
                    kind_acc = '0;
                    kind_st  = SCAN_NONE;
                end else if (b == C_ESC) begin
                    // The second ESC stays pending in its turn.
                    queue_event(make_event(KEY_BITS'(C_ESC), C_PRESS, 1'b1));
                end else begin
                    phase = PH_GROUND;
                    queue_event(make_event(KEY_BITS'(C_ESC), C_PRESS, 1'b0));
                    queue_event(make_event(KEY_BITS'(b), C_PRESS, 1'b1));
                end
            end
            default: begin
                if (b >= C_FINAL_LO && b <= C_FINAL_HI) begin
                    phase = PH_GROUND;
                    if (b == C_FINAL_U) begin
                        ok   = (key_st == SCAN_RUN) || (key_st == SCAN_DONE);
                        kind = C_PRESS;
                        if (field == FLD_KIND) begin
                            if (kind_st == SCAN_RUN || kind_st == SCAN_DONE) begin
                                kind = kind_acc[7:0];
                            end else begin
                                ok = 1'b0;
                            end
                        end
                        if (ok) begin
                            queue_event(make_event(key_acc[KEY_BITS-1:0], kind, 1'b1));
                        end
                    end
                end else begin
                    scan_digit(b, KEY_LIMIT, key_acc, key_st);
                    case (field)
                        FLD_KEY: begin
                            if (b == C_SEMI) field = FLD_MODS;
                        end
                        FLD_MODS: begin
                            if (b == C_COLON) begin
                                field    = FLD_KIND;
                                kind_acc = '0;
                                kind_st  = SCAN_NONE;
                            end
                        end
                        default: begin
                            scan_digit(b, KIND_LIMIT, kind_acc, kind_st);
                        end
                    endcase
                end
            end
        endcase
    endtask

    // Predict on each accepted byte, compare on each accepted word.
    always @(posedge i_clk) begin : watch_channels
        t_key_event want;
        t_key_event got;
        if (!i_rst_n) begin
            phase    = PH_GROUND;
            key_acc  = '0;
            key_st   = SCAN_NONE;
            field    = FLD_KEY;
            kind_acc = '0;
            kind_st  = SCAN_NONE;
            due_events.delete();
        end else begin
            if (i_byte_valid && i_byte_ready) begin
                decode_byte(i_data_byte);
            end
            if (i_event_valid && i_event_ready) begin
                got = make_event(i_key_code, i_event_kind, i_last_of_run);
                if (due_events.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected word key %0d kind %0d last %0b",
                                 $realtime, got.key, got.kind, got.last);
                    end
                end else begin
                    want = due_events.pop_front();
                    if (got.key !== want.key || got.kind !== want.kind
                            || got.last !== want.last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: word mismatch key %0d/%0d kind %0d/%0d last %0b/%0b",
                                     $realtime, want.key, got.key, want.kind, got.kind,
                                     want.last, got.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_events.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

// Drives the key event decoder with terminal byte streams and gives the
// verdict from the checker's counts.
module tb
    import cekd_pkg::*;
;

    localparam int KEY_BITS       = 21;
    localparam int KEY_MAX        = (1 << KEY_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS   = 360;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic calm;
    int   sent = 0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;

    cekd_byte_if byte_ch ();
    cekd_event_if #(.KEY_BITS(KEY_BITS)) ev_ch ();

    csi_u_key_event_decoder #(
        .KEY_BITS(KEY_BITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (byte_ch),
        .o_event_ch(ev_ch)
    );

    key_event_checker #(
        .KEY_BITS(KEY_BITS)
    ) watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_ch.valid),
        .i_byte_ready (byte_ch.ready),
        .i_data_byte  (byte_ch.data_byte),
        .i_event_valid(ev_ch.valid),
        .i_event_ready(ev_ch.ready),
        .i_key_code   (ev_ch.key_code),
        .i_event_kind (ev_ch.event_kind),
        .i_last_of_run(ev_ch.last_of_run),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge i_clk) begin
        ev_ch.ready <= calm || ($urandom_range(99) >= 26);
    end

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (ev_ch.valid && ev_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and waits until
    // the decoder takes it.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 26) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        sent++;
        calm <= (sent >= 250) && (sent < 380);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // ESC '[' followed by the given body, final byte included if wanted.
    task automatic send_csi(input string body);
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_text(body);
    endtask

    // A CSI u sequence that is well formed in shape, with random numbers
    // that reach the overflow edges now and then.
    task automatic send_random_csi();
        string       body;
        int unsigned key_val;
        logic [7:0]  fin_byte;
        body = ($urandom_range(9) == 0) ? "0" : "";
        case ($urandom_range(3))
            0: key_val = $urandom_range(200);
            1: key_val = $urandom_range(KEY_MAX);
            2: key_val = KEY_MAX - 5 + $urandom_range(10);
            default: key_val = $urandom();
        endcase
        body = {body, $sformatf("%0d", key_val)};
        if ($urandom_range(3) != 0) begin
            body = {body, ";"};
            if ($urandom_range(1) == 0) body = {body, $sformatf("%0d", $urandom_range(15))};
            if ($urandom_range(3) != 0) begin
                body = {body, ":"};
                if ($urandom_range(9) != 0) begin
                    body = {body, $sformatf("%0d", ($urandom_range(4) == 0) ?
                                            250 + $urandom_range(10) : $urandom_range(3))};
                end
                if ($urandom_range(4) == 0) body = {body, ":", $sformatf("%0d", $urandom_range(99))};
            end
            if ($urandom_range(5) == 0) body = {body, ";", $sformatf("%0d", $urandom_range(999))};
        end
        send_csi(body);
        // Now and then a stray body byte, then the final byte.
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(8'h3f)));
        fin_byte = ($urandom_range(7) == 0) ? 8'($urandom_range(C_FINAL_HI, C_FINAL_LO))
                                            : C_FINAL_U;
        send_byte(fin_byte);
    endtask

    initial begin
        int start_count;
        i_rst_n           <= 1'b0;
        calm              <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: byte extremes, lone escapes and the CSI u cases.
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(C_ESC);
        send_byte(C_ESC);
        send_text("x");
        send_byte(C_ESC);
        send_byte(8'h7f);
        send_csi("9u");
        send_csi("0u");
        send_csi("007u");
        send_csi("2097151u");
        send_csi("2097152u");
        send_csi("u");
        send_csi("-5u");
        send_csi(" 5u");
        send_csi("65;1:3u");
        send_csi("65;1:255u");
        send_csi("65;1:256u");
        send_csi("65;1:u");
        send_csi("65;2u");
        send_csi("65:3;4u");
        send_csi("65;5:2:9u");
        send_csi("65;1:3A");
        send_csi("12;1:2;\200u");
        send_csi("4");
        send_byte(8'h80);
        send_byte(C_FINAL_U);

        // Random part: about half CSI u sequences, the rest noise.
        start_count = sent;
        while (sent - start_count < RANDOM_WORDS) begin
            case ($urandom_range(99)) inside
                [0:49]: send_random_csi();
                [50:64]: begin
                    send_byte(C_ESC);
                    send_byte(8'($urandom_range(255)));
                end
                [65:84]: send_byte(8'($urandom_range(255)));
                default: begin
                    send_byte(C_ESC);
                    send_byte(C_LBRACKET);
                    repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
                    if ($urandom_range(1) == 0) send_byte(C_FINAL_U);
                end
            endcase
        end
        byte_ch.valid <= 1'b0;

        // Drain the outstanding words, then give the decoder time to show
        // anything extra.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/cekd_pkg.sv
sv/cekd_if.sv
sv/cekd_core.sv
sv/csi_u_key_event_decoder.sv
sv/cekd_chk.sv
bench/key_event_checker.sv
bench/tb.sv
